// ----- hw/rtl/i2cm_pkg.sv -----
// i2cm_pkg: types and codes shared by the i2c master bit engine
// no dependencies; imported by i2cm_step and i2c_master_bit_engine
package i2cm_pkg;

  localparam int unsigned DlyW = 10;
  localparam int unsigned CntW = 4;

  // request codes on req_type; codes above REQ_READ act as a tick
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam logic [CntW-1:0] BitsPerByte = CntW'(8);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_STA_A  = 4'd1,
    PH_STA_B  = 4'd2,
    PH_STO_A  = 4'd3,
    PH_STO_B  = 4'd4,
    PH_WR_LO  = 4'd5,
    PH_WR_HI  = 4'd6,
    PH_WA_LO  = 4'd7,
    PH_WA_HI  = 4'd8,
    PH_WA_END = 4'd9,
    PH_RD_PRE = 4'd10,
    PH_RD_HI  = 4'd11,
    PH_RD_LO  = 4'd12,
    PH_RA_LO  = 4'd13,
    PH_RA_HI  = 4'd14
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [CntW-1:0]   bit_count;
    logic [7:0]        shift_reg;
    logic [DlyW-1:0]   delay_count;
    logic              scl_level;
    logic              sda_level;
    logic              ack_bit;
    logic              ack_to_send;
    logic [7:0]        rd_data;
  } state_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] wr_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_byte;
    logic       ack_seen;
  } result_t;

endpackage

// ----- hw/rtl/i2cm_step.sv -----
// i2cm_step: next-state logic of the bit sequencer for one word
// depends on i2cm_pkg
module i2cm_step import i2cm_pkg::*; (
  input  state_t          state_i,
  input  item_t           item_i,
  input  logic [DlyW-1:0] ticks_per_delay_i,
  output state_t          state_o,
  output logic            done_o
);

  logic [DlyW-1:0] limit;
  logic [DlyW-1:0] dly_inc;
  logic [CntW-1:0] bit_inc;
  logic            fin;

  assign limit   = (ticks_per_delay_i == '0) ? DlyW'(1) : ticks_per_delay_i;
  assign dly_inc = state_i.delay_count + DlyW'(1);
  assign bit_inc = state_i.bit_count + CntW'(1);

  always_comb begin
    state_o = state_i;
    fin     = 1'b0;
    if (state_i.phase == PH_IDLE) begin
      state_o.delay_count = '0;
      state_o.bit_count   = '0;
      case (item_i.req_type)
        REQ_START: begin
          state_o.sda_level = 1'b1;
          state_o.scl_level = 1'b1;
          state_o.phase     = PH_STA_A;
        end
        REQ_STOP: begin
          state_o.sda_level = 1'b0;
          state_o.scl_level = 1'b1;
          state_o.phase     = PH_STO_A;
        end
        REQ_WRITE: begin
          state_o.shift_reg = item_i.wr_byte;
          state_o.scl_level = 1'b0;
          state_o.sda_level = item_i.wr_byte[7];
          state_o.phase     = PH_WR_LO;
        end
        REQ_READ: begin
          state_o.shift_reg   = '0;
          state_o.ack_to_send = item_i.send_ack;
          state_o.sda_level   = 1'b1;
          state_o.scl_level   = 1'b0;
          state_o.phase       = PH_RD_PRE;
        end
        default: ;
      endcase
    end else begin
      state_o.delay_count = dly_inc;
      if (dly_inc >= limit) begin
        state_o.delay_count = '0;
        case (state_i.phase)
          PH_STA_A: begin
            state_o.sda_level = 1'b0;
            state_o.phase     = PH_STA_B;
          end
          PH_STA_B: begin
            state_o.scl_level = 1'b0;
            fin = 1'b1;
          end
          PH_STO_A: begin
            state_o.sda_level = 1'b1;
            state_o.scl_level = 1'b0;
            state_o.phase     = PH_STO_B;
          end
          PH_STO_B: begin
            state_o.scl_level = 1'b1;
            fin = 1'b1;
          end
          PH_WR_LO: begin
            state_o.scl_level = 1'b1;
            state_o.phase     = PH_WR_HI;
          end
          PH_WR_HI: begin
            state_o.scl_level = 1'b0;
            state_o.shift_reg = {state_i.shift_reg[6:0], 1'b0};
            state_o.bit_count = bit_inc;
            if (bit_inc < BitsPerByte) begin
              state_o.sda_level = state_i.shift_reg[6];
              state_o.phase     = PH_WR_LO;
            end else begin
              state_o.sda_level = 1'b1;
              state_o.phase     = PH_WA_LO;
            end
          end
          PH_WA_LO: begin
            state_o.scl_level = 1'b1;
            state_o.phase     = PH_WA_HI;
          end
          PH_WA_HI: begin
            state_o.ack_bit   = item_i.sda_in;
            state_o.scl_level = 1'b0;
            state_o.phase     = PH_WA_END;
          end
          PH_RD_PRE: begin
            state_o.scl_level = 1'b1;
            state_o.phase     = PH_RD_HI;
          end
          PH_RD_HI: begin
            state_o.shift_reg = {state_i.shift_reg[6:0], item_i.sda_in};
            state_o.scl_level = 1'b0;
            state_o.phase     = PH_RD_LO;
          end
          PH_RD_LO: begin
            state_o.bit_count = bit_inc;
            if (bit_inc < BitsPerByte) begin
              state_o.scl_level = 1'b1;
              state_o.phase     = PH_RD_HI;
            end else begin
              state_o.sda_level = ~state_i.ack_to_send;
              state_o.phase     = PH_RA_LO;
            end
          end
          PH_RA_LO: begin
            state_o.scl_level = 1'b1;
            state_o.phase     = PH_RA_HI;
          end
          PH_RA_HI: begin
            state_o.scl_level = 1'b0;
            state_o.rd_data   = state_i.shift_reg;
            fin = 1'b1;
          end
          default: fin = 1'b1;  // end of write ack delay
        endcase
        if (fin) begin
          state_o.phase     = PH_IDLE;
          state_o.bit_count = '0;
        end
      end
    end
  end

  assign done_o = fin;

endmodule

// ----- hw/rtl/i2c_master_bit_engine.sv -----
// i2c_master_bit_engine: top level of the command/tick driven i2c master
// depends on i2cm_pkg and i2cm_step
//
// Each input word is either a command (start, stop, write byte, read byte) or a
// tick. A command taken while idle sets the first pin levels of its sequence;
// every later word counts one tick, and after ticks_per_delay ticks (zero acts
// as one) the next scl/sda step is taken. Every word gives exactly one result
// word with the pin levels, busy, done, the last read byte and the last write
// ack. One word is taken per clock cycle when the output side keeps up; a word
// goes through an input register, one pass of the step logic and a result
// register. The sequencer state updates in that single pass, which is what sets
// the rate. ticks_per_delay is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while idle, and the block itself does not enforce this.
module i2c_master_bit_engine import i2cm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration
  input  logic            cfg_we_i,
  input  logic [DlyW-1:0] cfg_wdata_i,
  // input words
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      req_type_i,
  input  logic [7:0]      wr_byte_i,
  input  logic            send_ack_i,
  input  logic            sda_in_i,
  // result words
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            scl_out_o,
  output logic            sda_release_o,
  output logic            busy_res_o,
  output logic            done_res_o,
  output logic [7:0]      rd_byte_o,
  output logic            ack_seen_o
);

  // delay length register
  logic [DlyW-1:0] tpd_q;

  // input register
  logic   in_valid_q, in_valid_d;
  item_t  item_q;

  // sequencer state
  state_t state_q, state_d;
  logic   step_done;

  // result register
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  logic adv;  // word moves from input register into result register
  logic in_acc;

  assign adv        = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | adv;
  assign in_acc     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpd_q <= DlyW'(1);
    end else if (cfg_we_i) begin
      tpd_q <= cfg_wdata_i;
    end
  end

  // input stage
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= '{req_type: req_type_i, wr_byte: wr_byte_i,
                  send_ack: send_ack_i, sda_in: sda_in_i};
    end
  end

  // sequencer step
  i2cm_step u_step (
    .state_i           (state_q),
    .item_i            (item_q),
    .ticks_per_delay_i (tpd_q),
    .state_o           (state_d),
    .done_o            (step_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, bit_count: '0, shift_reg: '0, delay_count: '0,
                   scl_level: 1'b1, sda_level: 1'b1, ack_bit: 1'b0,
                   ack_to_send: 1'b0, rd_data: '0};
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  // result stage
  assign res_d = '{scl_out:     state_d.scl_level,
                   sda_release: state_d.sda_level,
                   busy_res:    (state_d.phase != PH_IDLE),
                   done_res:    step_done,
                   rd_byte:     state_d.rd_data,
                   ack_seen:    state_d.ack_bit};

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_out_o     = res_q.scl_out;
  assign sda_release_o = res_q.sda_release;
  assign busy_res_o    = res_q.busy_res;
  assign done_res_o    = res_q.done_res;
  assign rd_byte_o     = res_q.rd_byte;
  assign ack_seen_o    = res_q.ack_seen;

`ifndef ASSERT_OFF
  // a finishing word never reports busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.done_res) |-> !res_q.busy_res)
    else $error("done and busy in the same result word");

  // idle sequencer keeps its counters cleared
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_IDLE) |-> (state_q.delay_count == '0 && state_q.bit_count == '0))
    else $error("counters not cleared while idle");

  // bit counter never passes one byte
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bit_count <= BitsPerByte)
    else $error("bit counter out of range");

  // a tick while idle leaves the pins alone
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && state_q.phase == PH_IDLE && item_q.req_type == REQ_TICK)
      |=> (state_q.scl_level == $past(state_q.scl_level)
           && state_q.sda_level == $past(state_q.sda_level)))
    else $error("pins moved on an idle tick");
`endif

endmodule
